// ----- hdl/bdl_pkg.sv -----
// Shared types and codes of the bounded deque list.
package bdl_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;

	localparam int unsigned FUNC_W = 3;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned LEN_W  = 5;

	typedef logic [FUNC_W-1:0]       func_t;
	typedef logic [STAT_W-1:0]       status_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [LEN_W-1:0]        len_t;

	// Operation codes
	localparam func_t FN_PUSH_FRONT = 3'd0;
	localparam func_t FN_PUSH_BACK  = 3'd1;
	localparam func_t FN_POP_FRONT  = 3'd2;
	localparam func_t FN_POP_BACK   = 3'd3;
	localparam func_t FN_DUMP       = 3'd4;

	// Status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef struct packed {
		func_t func;
		val_t  value;
	} req_item_t;

	typedef struct packed {
		status_t status;
		val_t    value_out;
		len_t    length;
		logic    last;
	} rsp_item_t;

endpackage

// ----- hdl/bounded_deque_list.sv -----
// Bounded double-ended list of signed words kept in a ring buffer memory.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  req     | in        | req_valid/req_stall | func, value
//  rsp     | out       | rsp_valid/rsp_stall | status, value_out, length, last
//
// Flow: an item is taken in idle and executed once the output register is
// free. A pop waits in a read-wait state for the memory read data; a dump
// gives one entry per cycle from the single read port, unless stalled.
// Reset: clears the length and the front pointer; the entry memory is not
// cleared, as only entries inside the list are ever read.
// Stalls: a result waits in the output register; execution holds while the
// output register is full and stalled.
module bounded_deque_list #(
	parameter int unsigned DEPTH = bdl_pkg::DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  bdl_pkg::req_item_t   req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output bdl_pkg::rsp_item_t   rsp
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW:0]   WRAP_SUM = (CW+1)'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_DUMP
	} state_t;

	state_t              state_q;
	bdl_pkg::func_t      op_q;
	bdl_pkg::val_t       val_q;
	logic [PW-1:0]       front_q;
	logic [CW-1:0]       count_q;
	logic [PW-1:0]       dptr_q;
	logic [CW-1:0]       idx_q;
	logic                rsp_valid_q;
	bdl_pkg::rsp_item_t  rsp_q;

	// Entry memory: one write port, one registered read port
	logic [bdl_pkg::VAL_W-1:0] mem [DEPTH];
	logic [bdl_pkg::VAL_W-1:0] rd_q;

	logic          out_free;
	logic          is_empty;
	logic          is_full;
	logic          dump_last;
	logic          rsp_load;
	logic [CW:0]   sum_tail;
	logic [CW:0]   sum_back;
	logic [PW-1:0] tail_idx;
	logic [PW-1:0] back_idx;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic          rd_en;
	logic [PW-1:0] rd_addr;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == LAST_IDX) ? '0 : PW'(p + 1'b1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		ptr_dec = (p == '0) ? LAST_IDX : PW'(p - 1'b1);
	endfunction

	function automatic bdl_pkg::rsp_item_t mk_rsp(
		input bdl_pkg::status_t st,
		input bdl_pkg::val_t    v,
		input logic [CW-1:0]    len,
		input logic             lst
	);
		bdl_pkg::rsp_item_t r;
		r.status    = st;
		r.value_out = v;
		r.length    = bdl_pkg::len_t'(len);
		r.last      = lst;
		mk_rsp = r;
	endfunction

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q >= FULL_CNT);
	assign dump_last = (CW'(idx_q + 1'b1) == count_q);

	// Slot after the back entry, and the back entry itself, modulo DEPTH
	always_comb begin
		sum_tail = (CW+1)'(front_q) + (CW+1)'(count_q);
		sum_back = sum_tail - 1'b1;
		tail_idx = (sum_tail >= WRAP_SUM) ? PW'(sum_tail - WRAP_SUM) : PW'(sum_tail);
		back_idx = (sum_back >= WRAP_SUM) ? PW'(sum_back - WRAP_SUM) : PW'(sum_back);
	end

	// A result enters the output register this cycle; a pop or dump of a
	// non-empty list first waits for the read data in the read-wait or dump state
	always_comb begin
		rsp_load = 1'b0;
		case (state_q)
			S_EXEC: begin
				rsp_load = out_free && (is_empty || !(op_q inside {bdl_pkg::FN_POP_FRONT,
					bdl_pkg::FN_POP_BACK, bdl_pkg::FN_DUMP}));
			end
			S_RDWAIT, S_DUMP: begin
				rsp_load = out_free;
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	// Memory port control; reads and writes never fall in the same cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_idx;
		rd_en   = 1'b0;
		rd_addr = front_q;
		case (state_q)
			S_EXEC: begin
				if (out_free) begin
					case (op_q)
						bdl_pkg::FN_PUSH_FRONT: begin
							wr_en   = !is_full;
							wr_addr = ptr_dec(front_q);
						end
						bdl_pkg::FN_PUSH_BACK: begin
							wr_en   = !is_full;
							wr_addr = tail_idx;
						end
						bdl_pkg::FN_POP_FRONT: begin
							rd_en   = !is_empty;
							rd_addr = front_q;
						end
						bdl_pkg::FN_POP_BACK: begin
							rd_en   = !is_empty;
							rd_addr = back_idx;
						end
						bdl_pkg::FN_DUMP: begin
							rd_en   = !is_empty;
							rd_addr = front_q;
						end
						default: begin
							rd_en = 1'b0;
						end
					endcase
				end
			end
			S_DUMP: begin
				rd_en   = out_free && !dump_last;
				rd_addr = dptr_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Sequencer: holds state, list pointers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			val_q       <= '0;
			front_q     <= '0;
			count_q     <= '0;
			dptr_q      <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// load a new result, hold a stalled one, drop one once taken
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.func;
						val_q   <= req.value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						case (op_q)
							bdl_pkg::FN_PUSH_FRONT, bdl_pkg::FN_PUSH_BACK: begin
								state_q <= S_IDLE;
								if (is_full) begin
									rsp_q <= mk_rsp(bdl_pkg::ST_FULL, '0, count_q, 1'b1);
								end else begin
									if (op_q == bdl_pkg::FN_PUSH_FRONT) begin
										front_q <= ptr_dec(front_q);
									end
									count_q <= CW'(count_q + 1'b1);
									rsp_q   <= mk_rsp(bdl_pkg::ST_OK, '0,
										CW'(count_q + 1'b1), 1'b1);
								end
							end
							bdl_pkg::FN_POP_FRONT, bdl_pkg::FN_POP_BACK: begin
								if (is_empty) begin
									rsp_q   <= mk_rsp(bdl_pkg::ST_EMPTY, '0, '0, 1'b1);
									state_q <= S_IDLE;
								end else begin
									if (op_q == bdl_pkg::FN_POP_FRONT) begin
										front_q <= ptr_inc(front_q);
									end
									count_q <= CW'(count_q - 1'b1);
									state_q <= S_RDWAIT;
								end
							end
							bdl_pkg::FN_DUMP: begin
								if (is_empty) begin
									rsp_q   <= mk_rsp(bdl_pkg::ST_EMPTY, '0, '0, 1'b1);
									state_q <= S_IDLE;
								end else begin
									dptr_q  <= ptr_inc(front_q);
									idx_q   <= '0;
									state_q <= S_DUMP;
								end
							end
							default: begin
								// unused codes: report the length and move on
								rsp_q   <= mk_rsp(bdl_pkg::ST_OK, '0, count_q, 1'b1);
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RDWAIT: begin
					if (out_free) begin
						rsp_q   <= mk_rsp(bdl_pkg::ST_OK, bdl_pkg::val_t'(rd_q),
							count_q, 1'b1);
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					// emit one entry and, unless it is the last, advance the read pointer
					if (out_free) begin
						rsp_q <= mk_rsp(bdl_pkg::ST_OK, bdl_pkg::val_t'(rd_q),
							count_q, dump_last);
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							dptr_q <= ptr_inc(dptr_q);
							idx_q  <= CW'(idx_q + 1'b1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond depth");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bdl_pkg::ST_FULL |-> rsp.length == bdl_pkg::len_t'(DEPTH))
		else $error("full status with list not full");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bdl_pkg::ST_EMPTY |-> rsp.length == '0 && rsp.value_out == '0
			&& rsp.last)
		else $error("empty status with bad fields");

	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> idx_q < count_q)
		else $error("dump index past list end");

endmodule

// ----- tb/bounded_deque_list_tb.sv -----
// Self-checking testbench for the bounded deque list: directed table, then random traffic.
`timescale 1ns / 1ps

module bounded_deque_list_tb;

	localparam int unsigned DEPTH       = bdl_pkg::DEPTH_DEFAULT;
	localparam int unsigned CYCLE_LIMIT = 500000;
	// Tail wait after the last result: a full dump plus pipeline slack.
	localparam int unsigned TAIL_CYCLES = DEPTH + 8;
	localparam int unsigned HOLD_CYCLES = 150;

	// Function codes the block ignores; each still gives one status result.
	localparam bdl_pkg::func_t FN_SPARE_LO  = 3'd5;
	localparam bdl_pkg::func_t FN_SPARE_MID = 3'd6;
	localparam bdl_pkg::func_t FN_SPARE_HI  = 3'd7;

	// One row of the directed table. A typed row carries its expected result;
	// every other row is checked against the predictor. Rows with reps > 1
	// repeat the operation, stepping the value by one each time.
	typedef struct packed {
		bdl_pkg::func_t   func;
		bdl_pkg::val_t    value;
		logic [4:0]       reps;
		logic             typed;
		bdl_pkg::status_t want_status;
		bdl_pkg::val_t    want_value;
		bdl_pkg::len_t    want_length;
	} dir_row_t;

	localparam int unsigned DIR_ROWS = 21;
	localparam dir_row_t DIRECTED[DIR_ROWS] = '{
		// Empty list: pops and dump all flag empty.
		'{bdl_pkg::FN_POP_FRONT, 32'sh0000_0000, 5'd1, 1'b1, bdl_pkg::ST_EMPTY, 32'sh0, 5'd0},
		'{bdl_pkg::FN_POP_BACK, 32'sh5A5A_5A5A, 5'd1, 1'b1, bdl_pkg::ST_EMPTY, 32'sh0, 5'd0},
		'{bdl_pkg::FN_DUMP, 32'sh0000_0000, 5'd1, 1'b1, bdl_pkg::ST_EMPTY, 32'sh0, 5'd0},
		// Pop back of a one-entry list empties it.
		'{bdl_pkg::FN_PUSH_BACK, 32'sh7FFF_FFFF, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'sh0, 5'd1},
		'{bdl_pkg::FN_POP_BACK, 32'sh0000_0000, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'sh7FFF_FFFF, 5'd0},
		// Push front from reset wraps the front pointer below zero.
		'{bdl_pkg::FN_PUSH_FRONT, 32'sh8000_0000, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'sh0, 5'd1},
		'{bdl_pkg::FN_PUSH_FRONT, 32'shFFFF_FFFF, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'sh0, 5'd2},
		'{bdl_pkg::FN_PUSH_BACK, 32'sh0000_0000, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'sh0, 5'd3},
		'{bdl_pkg::FN_DUMP, 32'sh0000_0000, 5'd1, 1'b0, bdl_pkg::ST_OK, 32'sh0, 5'd0},
		'{bdl_pkg::FN_POP_FRONT, 32'sh0000_0000, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'shFFFF_FFFF, 5'd2},
		// Unused codes: ignored, current length reported.
		'{FN_SPARE_LO, 32'sh0000_0000, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'sh0, 5'd2},
		'{FN_SPARE_MID, 32'sh1234_5678, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'sh0, 5'd2},
		'{FN_SPARE_HI, 32'shFFFF_FFFF, 5'd1, 1'b1, bdl_pkg::ST_OK, 32'sh0, 5'd2},
		// Fill to the top, then push at both ends onto a full list.
		'{bdl_pkg::FN_PUSH_BACK, 32'sh1234_5678, 5'd14, 1'b0, bdl_pkg::ST_OK, 32'sh0, 5'd0},
		'{bdl_pkg::FN_PUSH_BACK, 32'sh0000_0001, 5'd1, 1'b1, bdl_pkg::ST_FULL, 32'sh0, 5'd16},
		'{bdl_pkg::FN_PUSH_FRONT, 32'sh0000_0002, 5'd1, 1'b1, bdl_pkg::ST_FULL, 32'sh0, 5'd16},
		// Dump of a full list: the longest burst of results.
		'{bdl_pkg::FN_DUMP, 32'sh0000_0000, 5'd1, 1'b0, bdl_pkg::ST_OK, 32'sh0, 5'd0},
		'{bdl_pkg::FN_POP_BACK, 32'sh0000_0000, 5'd1, 1'b0, bdl_pkg::ST_OK, 32'sh0, 5'd0},
		'{bdl_pkg::FN_PUSH_FRONT, 32'sh0F0F_0F0F, 5'd1, 1'b0, bdl_pkg::ST_OK, 32'sh0, 5'd0},
		// Drain completely, then pop once more.
		'{bdl_pkg::FN_POP_FRONT, 32'sh0000_0000, 5'd16, 1'b0, bdl_pkg::ST_OK, 32'sh0, 5'd0},
		'{bdl_pkg::FN_POP_BACK, 32'sh0000_0000, 5'd1, 1'b1, bdl_pkg::ST_EMPTY, 32'sh0, 5'd0}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	bdl_pkg::req_item_t  req;
	logic                rsp_valid;
	logic                rsp_stall;
	bdl_pkg::rsp_item_t  rsp;

	// Shadow copy of the list, updated when an item is accepted.
	bdl_pkg::val_t shadow_entries[DEPTH];
	int unsigned   shadow_front;
	int unsigned   shadow_count;

	// Results still owed by the block, oldest first.
	bdl_pkg::rsp_item_t owed_results[$];

	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned stall_pct;
	int unsigned hold_left;

	bounded_deque_list #(
		.DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Apply one list operation to the shadow list and queue what it returns.
	task automatic apply_deque_op(input bdl_pkg::req_item_t op);
		bdl_pkg::rsp_item_t r;
		int unsigned        k;
		r        = '0;
		r.status = bdl_pkg::ST_OK;
		r.last   = 1'b1;
		case (op.func)
			bdl_pkg::FN_PUSH_FRONT, bdl_pkg::FN_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = bdl_pkg::ST_FULL;
				end else if (op.func == bdl_pkg::FN_PUSH_FRONT) begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_entries[shadow_front] = op.value;
					shadow_count++;
				end else begin
					shadow_entries[(shadow_front + shadow_count) % DEPTH] = op.value;
					shadow_count++;
				end
				r.length = bdl_pkg::len_t'(shadow_count);
				owed_results.push_back(r);
			end
			bdl_pkg::FN_POP_FRONT, bdl_pkg::FN_POP_BACK: begin
				if (shadow_count == 0) begin
					r.status = bdl_pkg::ST_EMPTY;
				end else if (op.func == bdl_pkg::FN_POP_FRONT) begin
					r.value_out  = shadow_entries[shadow_front];
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end else begin
					r.value_out = shadow_entries[(shadow_front + shadow_count - 1) % DEPTH];
					shadow_count--;
				end
				r.length = bdl_pkg::len_t'(shadow_count);
				owed_results.push_back(r);
			end
			bdl_pkg::FN_DUMP: begin
				if (shadow_count == 0) begin
					r.status = bdl_pkg::ST_EMPTY;
					owed_results.push_back(r);
				end else begin
					for (k = 0; k < shadow_count; k++) begin
						r.value_out = shadow_entries[(shadow_front + k) % DEPTH];
						r.length    = bdl_pkg::len_t'(shadow_count);
						r.last      = (k + 1 == shadow_count);
						owed_results.push_back(r);
					end
				end
			end
			default: begin
				r.length = bdl_pkg::len_t'(shadow_count);
				owed_results.push_back(r);
			end
		endcase
	endtask

	// Offer one item, idling first at random, and hold it until accepted.
	// Starts on a fresh falling edge and returns just after the accepting edge.
	task automatic send_item(input bdl_pkg::req_item_t op, input int unsigned idle_pct,
			input logic use_typed, input bdl_pkg::rsp_item_t typed_want);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req       = op;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		apply_deque_op(op);
		// A typed row owes exactly one result; swap in the typed-in one.
		if (use_typed) begin
			void'(owed_results.pop_back());
			owed_results.push_back(typed_want);
		end
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic wait_drained();
		@(negedge clk);
		req_valid = 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
	endtask

	// Random traffic: mostly pushes and pops steered by the fill level, so the
	// list sweeps between empty and full, with dumps and ignored codes mixed in.
	task automatic run_random(input int unsigned n_items, input int unsigned idle_pct);
		bdl_pkg::req_item_t op;
		bdl_pkg::rsp_item_t none;
		int unsigned        done;
		int unsigned        pick;
		none = '0;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				op.func = bdl_pkg::func_t'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
			end else if (pick < 12) begin
				op.func = bdl_pkg::FN_DUMP;
				done++;
			end else begin
				// Lean toward pushes when low, pops when high; flip now and then so
				// full pushes and empty pops show up too.
				if (($urandom_range(1, DEPTH) > shadow_count) ^ ($urandom_range(0, 19) == 0))
					op.func = $urandom_range(0, 1) ? bdl_pkg::FN_PUSH_FRONT
						: bdl_pkg::FN_PUSH_BACK;
				else
					op.func = $urandom_range(0, 1) ? bdl_pkg::FN_POP_FRONT
						: bdl_pkg::FN_POP_BACK;
				done++;
			end
			case ($urandom_range(0, 5))
				0: op.value = 32'sh7FFF_FFFF;
				1: op.value = 32'sh8000_0000;
				2: op.value = 32'sh0000_0000;
				default: op.value = bdl_pkg::val_t'($urandom);
			endcase
			send_item(op, idle_pct, 1'b0, none);
		end
	endtask

	// Receiver: stall at random, or hold off for a counted stretch on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			rsp_stall = ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Compare each accepted result with the oldest owed one.
	always @(posedge clk) begin : rsp_check
		bdl_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_results.size() == 0) begin
				$error("unexpected result: status %0d value_out %0d length %0d last %0b",
					rsp.status, rsp.value_out, rsp.length, rsp.last);
				fail_count++;
			end else begin
				want = owed_results.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.value_out !== want.value_out) begin
					$error("value_out: expected %0d, got %0d", want.value_out, rsp.value_out);
					fail_count++;
				end
				if (rsp.length !== want.length) begin
					$error("length: expected %0d, got %0d", want.length, rsp.length);
					fail_count++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, rsp.last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		bdl_pkg::req_item_t op;
		bdl_pkg::rsp_item_t want;
		dir_row_t           row;
		int unsigned        i;
		int unsigned        k;

		// Drive every input to a known value before reset lifts.
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		rsp_stall    = 1'b0;
		stall_pct    = 0;
		hold_left    = 0;
		fail_count   = 0;
		cycle_count  = 0;
		shadow_front = 0;
		shadow_count = 0;
		for (i = 0; i < DEPTH; i++) shadow_entries[i] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, back to back with no idling on either side.
		for (i = 0; i < DIR_ROWS; i++) begin
			row  = DIRECTED[i];
			want = '{row.want_status, row.want_value, row.want_length, 1'b1};
			for (k = 0; k < row.reps; k++) begin
				op.func  = row.func;
				op.value = row.value + bdl_pkg::val_t'(k);
				send_item(op, 0, row.typed, want);
			end
		end
		wait_drained();

		// Random phases: no idling, then a slow sender, then a slow receiver,
		// then both idling a third of the time.
		run_random(12, 0);
		wait_drained();
		run_random(12, 83);
		wait_drained();
		stall_pct = 83;
		run_random(12, 0);
		wait_drained();
		stall_pct = 33;
		run_random(12, 33);
		wait_drained();

		// Hold the receiver off for a long stretch while pushes keep coming, so
		// the output backs up and the block stalls its input.
		stall_pct = 0;
		hold_left = HOLD_CYCLES;
		want      = '0;
		for (i = 0; i < 10; i++) begin
			op.func  = (i % 2 == 0) ? bdl_pkg::FN_PUSH_BACK : bdl_pkg::FN_PUSH_FRONT;
			op.value = bdl_pkg::val_t'($urandom);
			send_item(op, 0, 1'b0, want);
		end
		op.func  = bdl_pkg::FN_DUMP;
		op.value = '0;
		send_item(op, 0, 1'b0, want);
		wait_drained();

		// Let any trailing activity settle, then report leftovers and the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		while (owed_results.size() != 0) begin
			want = owed_results.pop_front();
			$error("missing result: status %0d value_out %0d length %0d last %0b",
				want.status, want.value_out, want.length, want.last);
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bdl_pkg.sv
hdl/bounded_deque_list.sv
tb/bounded_deque_list_tb.sv
